// ----- rtl/irtd_pkg.sv -----
`default_nettype none

package irtd_pkg;

  localparam int unsigned FrameBitsDefault = 32;
  localparam int unsigned QueueDepth       = 2;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] LeaderLowReset    = 16'd120;
  localparam logic [15:0] LeaderHighReset   = 16'd140;
  localparam logic [15:0] BitThresholdReset = 16'd15;
  localparam logic [7:0]  CodeUpReset       = 8'h18;
  localparam logic [7:0]  CodeDownReset     = 8'h4A;
  localparam logic [7:0]  CodeOkReset       = 8'h38;
  localparam logic [7:0]  CodeModeReset     = 8'h68;

  localparam int unsigned NumDigits = 6;
  localparam logic [2:0]  LastPos   = 3'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEADER_LOW    = 3'd0,
    CFG_LEADER_HIGH   = 3'd1,
    CFG_BIT_THRESHOLD = 3'd2,
    CFG_CODE_UP       = 3'd3,
    CFG_CODE_DOWN     = 3'd4,
    CFG_CODE_OK       = 3'd5,
    CFG_CODE_MODE     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] leader_low;
    logic [15:0] leader_high;
    logic [15:0] bit_threshold;
    logic [7:0]  code_up;
    logic [7:0]  code_down;
    logic [7:0]  code_ok;
    logic [7:0]  code_mode;
  } cfg_t;

  typedef struct packed {
    logic       frame_done;
    logic [7:0] command;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } cmd_item_t;

endpackage

`default_nettype wire

// ----- rtl/irtd_front.sv -----
`default_nettype none

module irtd_front #(
  parameter int unsigned FRAME_BITS = irtd_pkg::FrameBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irtd_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         edge_time_i,
  input  logic [4:0]          now_hours_i,
  input  logic [5:0]          now_minutes_i,
  input  logic [5:0]          now_seconds_i,
  input  logic                full_i,
  output logic                push_o,
  output irtd_pkg::cmd_item_t item_o
);
  import irtd_pkg::*;

  localparam int unsigned CntW = $clog2(FRAME_BITS + 1);

  logic [15:0]           prev_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [CntW-1:0]       cnt_q;

  logic [15:0]           period;
  logic                  is_leader;
  logic                  is_one;
  logic                  is_zero;
  logic                  shift;
  logic [FRAME_BITS-1:0] frame_shifted;
  logic [31:0]           frame_ext;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign period    = edge_time_i - prev_q;
  assign is_leader = (period < cfg_i.leader_high) && (period > cfg_i.leader_low);
  assign is_one    = period > cfg_i.bit_threshold;
  assign is_zero   = period < cfg_i.bit_threshold;
  assign shift     = !is_leader && (cnt_q < CntW'(FRAME_BITS)) && (is_one || is_zero);

  // MSB first: after the last bit the frame sits aligned at bit 0
  assign frame_shifted = {frame_q[FRAME_BITS-2:0], is_one};
  assign frame_ext     = 32'(frame_shifted);

  always_comb begin
    item_o.frame_done = shift && (cnt_q == CntW'(FRAME_BITS - 1));
    item_o.command    = frame_ext[15:8];
    item_o.hours      = now_hours_i;
    item_o.minutes    = now_minutes_i;
    item_o.seconds    = now_seconds_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      frame_q <= '0;
      cnt_q   <= '0;
    end else if (push_o) begin
      prev_q <= edge_time_i;
      if (is_leader) begin
        frame_q <= '0;
        cnt_q   <= '0;
      end else if (shift) begin
        frame_q <= frame_shifted;
        cnt_q   <= cnt_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/irtd_queue.sv -----
`default_nettype none

module irtd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  irtd_pkg::cmd_item_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output irtd_pkg::cmd_item_t data_o
);
  import irtd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_item_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- rtl/irtd_back.sv -----
`default_nettype none

module irtd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irtd_pkg::cfg_t      cfg_i,
  input  logic                empty_i,
  input  irtd_pkg::cmd_item_t item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                frame_done_o,
  output logic [7:0]          command_code_o,
  output logic                setting_active_o,
  output logic [2:0]          edit_position_o,
  output logic [23:0]         digits_packed_o,
  output logic                commit_strobe_o,
  output logic [4:0]          commit_hours_o,
  output logic [5:0]          commit_minutes_o,
  output logic [5:0]          commit_seconds_o
);
  import irtd_pkg::*;

  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'd13;
    return {1'b0, p[9:7]};
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [3:0] t;
    logic [5:0] tt;
    t  = tens_of(v);
    tt = 6'({t, 3'b000}) + 6'({t, 1'b0});
    return 4'(v - tt);
  endfunction

  function automatic logic [7:0] join_digits(input logic [3:0] t, input logic [3:0] u);
    return 8'({t, 3'b000}) + 8'({t, 1'b0}) + 8'(u);
  endfunction

  logic                          setting_q, setting_d;
  logic [2:0]                    pos_q, pos_d;
  logic [NumDigits-1:0][3:0]     dig_q, dig_d;
  logic [7:0]                    last_q, last_d;

  logic                          out_valid_q;
  logic                          out_done_q;
  logic                          out_commit_q;
  logic [4:0]                    out_ch_q;
  logic [5:0]                    out_cm_q;
  logic [5:0]                    out_cs_q;

  logic                          commit;
  logic [4:0]                    ch;
  logic [5:0]                    cm;
  logic [5:0]                    cs;
  logic [3:0]                    cur;
  logic [3:0]                    maxv;
  logic [4:0]                    inc;
  logic [3:0]                    dec;
  logic [7:0]                    jh, jm, js;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  assign cur  = dig_q[pos_q];
  assign inc  = 5'(cur) + 5'd1;
  assign dec  = cur - 4'd1;
  assign jh   = join_digits(dig_q[5], dig_q[4]);
  assign jm   = join_digits(dig_q[3], dig_q[2]);
  assign js   = join_digits(dig_q[1], dig_q[0]);

  always_comb begin
    if (pos_q == LastPos) begin
      maxv = (dig_q[4] <= 4'd4) ? 4'd2 : 4'd1;
    end else if (pos_q == 3'd1 || pos_q == 3'd3) begin
      maxv = 4'd5;
    end else begin
      maxv = 4'd9;
    end
  end

  always_comb begin
    setting_d = setting_q;
    pos_d     = pos_q;
    dig_d     = dig_q;
    last_d    = last_q;
    commit    = 1'b0;
    ch        = '0;
    cm        = '0;
    cs        = '0;
    if (item_i.frame_done) begin
      last_d = item_i.command;
      if (item_i.command == cfg_i.code_mode) begin
        setting_d = !setting_q;
        if (!setting_q) begin
          dig_d[0] = units_of(item_i.seconds);
          dig_d[1] = tens_of(item_i.seconds);
          dig_d[2] = units_of(item_i.minutes);
          dig_d[3] = tens_of(item_i.minutes);
          dig_d[4] = units_of(6'(item_i.hours));
          dig_d[5] = tens_of(6'(item_i.hours));
          pos_d    = '0;
        end
      end else if (item_i.command == cfg_i.code_up) begin
        if (setting_q && pos_q <= LastPos) begin
          dig_d[pos_q] = (inc > 5'(maxv)) ? 4'd0 : inc[3:0];
        end
      end else if (item_i.command == cfg_i.code_down) begin
        if (setting_q && pos_q <= LastPos) begin
          // a digit still above the limit after the step wraps to zero
          dig_d[pos_q] = (cur == 4'd0) ? maxv : ((dec > maxv) ? 4'd0 : dec);
        end
      end else if (item_i.command == cfg_i.code_ok) begin
        if (setting_q) begin
          if (pos_q == LastPos || pos_q == LastPos + 3'd1) begin
            pos_d     = '0;
            setting_d = 1'b0;
            commit    = 1'b1;
            ch        = (jh > 8'd31) ? 5'd31 : jh[4:0];
            cm        = (jm > 8'd63) ? 6'd63 : jm[5:0];
            cs        = (js > 8'd63) ? 6'd63 : js[5:0];
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting_q   <= 1'b0;
      pos_q       <= '0;
      dig_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        setting_q   <= setting_d;
        pos_q       <= pos_d;
        dig_q       <= dig_d;
        last_q      <= last_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_done_q   <= item_i.frame_done;
      out_commit_q <= commit;
      out_ch_q     <= ch;
      out_cm_q     <= cm;
      out_cs_q     <= cs;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_done_o     = out_done_q;
  assign command_code_o   = last_q;
  assign setting_active_o = setting_q;
  assign edit_position_o  = pos_q;
  assign digits_packed_o  = dig_q;
  assign commit_strobe_o  = out_commit_q;
  assign commit_hours_o   = out_ch_q;
  assign commit_minutes_o = out_cm_q;
  assign commit_seconds_o = out_cs_q;

  a_commit_leaves_setting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_commit_q |-> out_done_q && !setting_q && pos_q == '0)
    else $error("commit without leaving setting mode");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("edit position out of range");

  a_edit_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !item_i.frame_done |=> $stable(dig_q) && $stable(setting_q))
    else $error("editor changed without a completed frame");

endmodule

`default_nettype wire

// ----- rtl/ir_remote_time_setting_decoder_unit.sv -----
// Each input is held in a queue entry, and its result is then registered in the output register.
// Throughput: one item per cycle; the front stalls only when the 2-entry queue is full.
// A stalled output register holds its result while the queue keeps filling.
// Reset (rst_ni low, asynchronous): config registers to defaults, decoder and editor state
// to zero, queue and output register empty.
`default_nettype none

module ir_remote_time_setting_decoder_unit #(
  parameter int unsigned FRAME_BITS = irtd_pkg::FrameBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irtd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irtd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [15:0]                   edge_time_i,
  input  logic [4:0]                    now_hours_i,
  input  logic [5:0]                    now_minutes_i,
  input  logic [5:0]                    now_seconds_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          frame_done_o,
  output logic [7:0]                    command_code_o,
  output logic                          setting_active_o,
  output logic [2:0]                    edit_position_o,
  output logic [23:0]                   digits_packed_o,
  output logic                          commit_strobe_o,
  output logic [4:0]                    commit_hours_o,
  output logic [5:0]                    commit_minutes_o,
  output logic [5:0]                    commit_seconds_o
);
  import irtd_pkg::*;

  cfg_t      cfg_q;
  cmd_item_t push_item;
  cmd_item_t pop_item;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low    <= LeaderLowReset;
      cfg_q.leader_high   <= LeaderHighReset;
      cfg_q.bit_threshold <= BitThresholdReset;
      cfg_q.code_up       <= CodeUpReset;
      cfg_q.code_down     <= CodeDownReset;
      cfg_q.code_ok       <= CodeOkReset;
      cfg_q.code_mode     <= CodeModeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEADER_LOW:    cfg_q.leader_low    <= cfg_data_i;
        CFG_LEADER_HIGH:   cfg_q.leader_high   <= cfg_data_i;
        CFG_BIT_THRESHOLD: cfg_q.bit_threshold <= cfg_data_i;
        CFG_CODE_UP:       cfg_q.code_up       <= cfg_data_i[7:0];
        CFG_CODE_DOWN:     cfg_q.code_down     <= cfg_data_i[7:0];
        CFG_CODE_OK:       cfg_q.code_ok       <= cfg_data_i[7:0];
        CFG_CODE_MODE:     cfg_q.code_mode     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  irtd_front #(
    .FRAME_BITS (FRAME_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .edge_time_i   (edge_time_i),
    .now_hours_i   (now_hours_i),
    .now_minutes_i (now_minutes_i),
    .now_seconds_i (now_seconds_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  irtd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_item)
  );

  irtd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .empty_i          (empty),
    .item_i           (pop_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_done_o     (frame_done_o),
    .command_code_o   (command_code_o),
    .setting_active_o (setting_active_o),
    .edit_position_o  (edit_position_o),
    .digits_packed_o  (digits_packed_o),
    .commit_strobe_o  (commit_strobe_o),
    .commit_hours_o   (commit_hours_o),
    .commit_minutes_o (commit_minutes_o),
    .commit_seconds_o (commit_seconds_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import irtd_pkg::*;

  localparam int FrameLen      = FrameBitsDefault;
  localparam int HoldCycles    = 60;
  localparam int WatchdogLimit = 2000;

  typedef struct {
    logic        frame_done;
    logic [7:0]  command;
    logic        setting;
    logic [2:0]  position;
    logic [23:0] digits;
    logic        commit;
    logic [4:0]  c_hours;
    logic [5:0]  c_minutes;
    logic [5:0]  c_seconds;
  } frame_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [15:0]         edge_time_i;
  logic [4:0]          now_hours_i;
  logic [5:0]          now_minutes_i;
  logic [5:0]          now_seconds_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                frame_done_o;
  logic [7:0]          command_code_o;
  logic                setting_active_o;
  logic [2:0]          edit_position_o;
  logic [23:0]         digits_packed_o;
  logic                commit_strobe_o;
  logic [4:0]          commit_hours_o;
  logic [5:0]          commit_minutes_o;
  logic [5:0]          commit_seconds_o;

  ir_remote_time_setting_decoder_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .edge_time_i      (edge_time_i),
    .now_hours_i      (now_hours_i),
    .now_minutes_i    (now_minutes_i),
    .now_seconds_i    (now_seconds_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_done_o     (frame_done_o),
    .command_code_o   (command_code_o),
    .setting_active_o (setting_active_o),
    .edit_position_o  (edit_position_o),
    .digits_packed_o  (digits_packed_o),
    .commit_strobe_o  (commit_strobe_o),
    .commit_hours_o   (commit_hours_o),
    .commit_minutes_o (commit_minutes_o),
    .commit_seconds_o (commit_seconds_o)
  );

  // decoder mirror
  cfg_t        cfg_m;
  logic [15:0] prev_stamp = '0;
  logic [31:0] frame_sr   = '0;
  logic [5:0]  bit_cnt    = '0;
  logic [7:0]  last_cmd   = '0;
  logic        in_setting = 1'b0;
  logic [2:0]  pos        = '0;
  logic [3:0]  digit_q [NumDigits] = '{default: '0};

  frame_result_t pending_results [$];

  int   mismatches     = 0;
  int   items_sent     = 0;
  int   stalled_cycles = 0;
  int   send_idle_pct  = 29;
  int   recv_idle_pct  = 66;
  bit   hold_req       = 1'b0;
  bit   hold_now       = 1'b0;
  logic [4:0] now_h = '0;
  logic [5:0] now_m = '0;
  logic [5:0] now_s = '0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_leader(logic [15:0] p);
    return p < cfg_m.leader_high && p > cfg_m.leader_low;
  endfunction

  function automatic void step_digit(int delta);
    int top;
    int v;
    if (pos == LastPos) top = (digit_q[4] <= 4) ? 2 : 1;
    else if (pos == 3'd1 || pos == 3'd3) top = 5;
    else top = 9;
    v = int'(digit_q[pos]) + delta;
    if (v > top) v = 0;
    if (v < 0) v = top;
    digit_q[pos] = v[3:0];
  endfunction

  function automatic int unsigned pair_value(logic [3:0] tens, logic [3:0] units,
                                             int unsigned cap);
    int unsigned v;
    v = tens * 10 + units;
    return (v > cap) ? cap : v;
  endfunction

  task automatic decode_edge(input logic [15:0] stamp, input logic [4:0] hrs,
                             input logic [5:0] mins, input logic [5:0] secs);
    logic [15:0]   period;
    logic [7:0]    cmd;
    frame_result_t r;
    r = '{default: '0};
    period = stamp - prev_stamp;
    prev_stamp = stamp;
    if (is_leader(period)) begin
      frame_sr = '0;
      bit_cnt = '0;
    end else if (bit_cnt < FrameLen && period != cfg_m.bit_threshold) begin
      if (period > cfg_m.bit_threshold) frame_sr[FrameLen - 1 - bit_cnt] = 1'b1;
      bit_cnt = bit_cnt + 6'd1;
      r.frame_done = (bit_cnt == FrameLen);
    end
    if (r.frame_done) begin
      cmd = frame_sr[15:8];
      last_cmd = cmd;
      if (cmd == cfg_m.code_mode) begin
        in_setting = !in_setting;
        if (in_setting) begin
          digit_q[0] = 4'(secs % 10);
          digit_q[1] = 4'(secs / 10);
          digit_q[2] = 4'(mins % 10);
          digit_q[3] = 4'(mins / 10);
          digit_q[4] = 4'(hrs % 10);
          digit_q[5] = 4'(hrs / 10);
          pos = '0;
        end
      end else if (cmd == cfg_m.code_up) begin
        if (in_setting) step_digit(1);
      end else if (cmd == cfg_m.code_down) begin
        if (in_setting) step_digit(-1);
      end else if (cmd == cfg_m.code_ok) begin
        if (in_setting) begin
          if (pos == LastPos) begin
            pos = '0;
            in_setting = 1'b0;
            r.commit = 1'b1;
            r.c_hours   = 5'(pair_value(digit_q[5], digit_q[4], 31));
            r.c_minutes = 6'(pair_value(digit_q[3], digit_q[2], 63));
            r.c_seconds = 6'(pair_value(digit_q[1], digit_q[0], 63));
          end else begin
            pos = pos + 3'd1;
          end
        end
      end
    end
    r.command  = last_cmd;
    r.setting  = in_setting;
    r.position = pos;
    r.digits   = {digit_q[5], digit_q[4], digit_q[3], digit_q[2], digit_q[1], digit_q[0]};
    pending_results.push_back(r);
  endtask

  // called at a falling edge; returns at a falling edge with nothing driven there yet
  task automatic send_edge(input logic [15:0] stamp, input logic [4:0] hrs,
                           input logic [5:0] mins, input logic [5:0] secs);
    int gap;
    in_valid_i    <= 1'b1;
    edge_time_i   <= stamp;
    now_hours_i   <= hrs;
    now_minutes_i <= mins;
    now_seconds_i <= secs;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    decode_edge(stamp, hrs, mins, secs);
    items_sent++;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i  <= 1'b0;
      edge_time_i <= 16'($urandom);
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_gap(input logic [15:0] period);
    if (!hold_now) begin
      now_h = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(23));
      now_m = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(59));
      now_s = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(59));
    end
    send_edge(prev_stamp + period, now_h, now_m, now_s);
  endtask

  function automatic logic [15:0] leader_period();
    if (int'(cfg_m.leader_high) - int'(cfg_m.leader_low) < 2) return 16'($urandom);
    return 16'($urandom_range(int'(cfg_m.leader_high) - 1, int'(cfg_m.leader_low) + 1));
  endfunction

  function automatic logic [15:0] bit_period(bit one);
    int          lo;
    int          hi;
    int          span;
    int          cand [4];
    logic [15:0] p;
    lo = one ? int'(cfg_m.bit_threshold) + 1 : 0;
    hi = one ? 65535 : int'(cfg_m.bit_threshold) - 1;
    if (lo > hi) return 16'($urandom);
    span = (hi - lo < 3) ? hi - lo : 3;
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(1)) p = 16'($urandom_range(hi, lo));
      else p = one ? 16'(lo + $urandom_range(span)) : 16'(hi - $urandom_range(span));
      if (!is_leader(p)) return p;
    end
    cand = '{lo, hi, int'(cfg_m.leader_low), int'(cfg_m.leader_high)};
    foreach (cand[i])
      if (cand[i] >= lo && cand[i] <= hi && !is_leader(16'(cand[i]))) return 16'(cand[i]);
    return p;
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(4))
      0: return cfg_m.code_mode;
      1: return cfg_m.code_up;
      2: return cfg_m.code_down;
      3: return cfg_m.code_ok;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] cmd);
    logic [31:0] word;
    word = $urandom;
    word[15:8] = cmd;
    send_gap(leader_period());
    for (int i = FrameLen - 1; i >= 0; i--) send_gap(bit_period(word[i]));
  endtask

  task automatic run_session();
    int n;
    if (!in_setting) send_frame(cfg_m.code_mode);
    for (int p = 0; p < NumDigits; p++) begin
      n = $urandom_range(2);
      repeat (n) send_frame($urandom_range(1) ? cfg_m.code_up : cfg_m.code_down);
      if ($urandom_range(15) == 0) send_frame(pick_command());
      send_frame(cfg_m.code_ok);
    end
  endtask

  task automatic send_noise();
    int n;
    case ($urandom_range(4))
      0: begin
        n = $urandom_range(1, 8);
        repeat (n) send_gap(16'($urandom));
      end
      1: send_gap(cfg_m.bit_threshold);
      2: send_gap(leader_period());
      3: begin
        // truncated frame
        n = $urandom_range(1, FrameLen - 1);
        send_gap(leader_period());
        repeat (n) send_gap(bit_period($urandom_range(1)));
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) send_gap(bit_period($urandom_range(1)));
      end
    endcase
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(CFG_LEADER_LOW, s.leader_low);
    write_reg(CFG_LEADER_HIGH, s.leader_high);
    write_reg(CFG_BIT_THRESHOLD, s.bit_threshold);
    write_reg(CFG_CODE_UP, 16'(s.code_up));
    write_reg(CFG_CODE_DOWN, 16'(s.code_down));
    write_reg(CFG_CODE_OK, 16'(s.code_ok));
    write_reg(CFG_CODE_MODE, 16'(s.code_mode));
    cfg_we_i <= 1'b0;
    cfg_m = s;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_edge_cases();
    hold_now = 1'b1;
    now_h = '0;
    now_m = '0;
    now_s = '0;
    send_edge(16'h0000, 5'd0, 6'd0, 6'd0);
    send_edge(16'hFFFF, 5'd31, 6'd63, 6'd63);
    send_gap(cfg_m.bit_threshold);
    send_gap(cfg_m.bit_threshold - 16'd1);
    send_gap(cfg_m.bit_threshold + 16'd1);
    send_gap(cfg_m.leader_low);
    send_gap(cfg_m.leader_high);
    send_gap(cfg_m.leader_low + 16'd1);
    send_gap(cfg_m.leader_high - 16'd1);
    send_edge(16'hFFF0, 5'd23, 6'd59, 6'd59);
    send_edge(16'h0005, 5'd0, 6'd0, 6'd0);
    hold_now = 1'b0;
  endtask

  task automatic test_commands();
    send_frame(cfg_m.code_up);
    send_frame(cfg_m.code_ok);
    send_frame(8'h00);
    // entry with out-of-range time, edits that overflow the commit fields
    hold_now = 1'b1;
    now_h = 5'd31;
    now_m = 6'd63;
    now_s = 6'd60;
    send_frame(cfg_m.code_mode);
    send_frame(cfg_m.code_down);
    send_frame(cfg_m.code_ok);
    send_frame(cfg_m.code_ok);
    send_frame(cfg_m.code_up);
    send_frame(cfg_m.code_ok);
    send_frame(cfg_m.code_ok);
    send_frame(cfg_m.code_up);
    send_frame(cfg_m.code_ok);
    send_frame(cfg_m.code_ok);
    // wraps, then leave without commit
    now_h = 5'd23;
    now_m = 6'd59;
    now_s = 6'd59;
    send_frame(cfg_m.code_mode);
    send_frame(cfg_m.code_up);
    send_frame(cfg_m.code_ok);
    send_frame(cfg_m.code_up);
    send_frame(cfg_m.code_mode);
    hold_now = 1'b0;
    // bits past a full frame
    send_frame(8'h00);
    repeat (3) send_gap(bit_period(1'b1));
  endtask

  task automatic test_traffic(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_frame(pick_command());
        4, 5:       run_session();
        default:    send_noise();
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) send_gap(bit_period($urandom_range(1)));
    drain();
  endtask

  // result side
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_done", want.frame_done, frame_done_o);
        check_field("command_code", want.command, command_code_o);
        check_field("setting_active", want.setting, setting_active_o);
        check_field("edit_position", want.position, edit_position_o);
        check_field("digits_packed", want.digits, digits_packed_o);
        check_field("commit_strobe", want.commit, commit_strobe_o);
        check_field("commit_hours", want.c_hours, commit_hours_o);
        check_field("commit_minutes", want.c_minutes, commit_minutes_o);
        check_field("commit_seconds", want.c_seconds, commit_seconds_o);
      end
    end
  end

  initial begin
    while (stalled_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled_cycles = 0;
      else stalled_cycles++;
    end
    $display("ir_remote_time_setting_decoder_unit: mismatch");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_LEADER_LOW;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    edge_time_i   = '0;
    now_hours_i   = '0;
    now_minutes_i = '0;
    now_seconds_i = '0;
    cfg_m = '{leader_low: LeaderLowReset, leader_high: LeaderHighReset,
              bit_threshold: BitThresholdReset, code_up: CodeUpReset,
              code_down: CodeDownReset, code_ok: CodeOkReset, code_mode: CodeModeReset};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 66;
    apply_settings(cfg_m);
    test_edge_cases();
    test_commands();
    test_traffic(250);
    drain();

    // up and down share a code
    send_idle_pct = 66;
    recv_idle_pct = 29;
    apply_settings('{leader_low: 16'd1000, leader_high: 16'd1200, bit_threshold: 16'd300,
                     code_up: 8'hA5, code_down: 8'hA5, code_ok: 8'h3C, code_mode: 8'h00});
    test_traffic(250);
    drain();

    // widest leader window; mode shares the ok code
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings('{leader_low: 16'h0000, leader_high: 16'hFFFF, bit_threshold: 16'd1,
                     code_up: 8'hFF, code_down: 8'h00, code_ok: 8'h7E, code_mode: 8'h7E});
    test_backpressure();
    test_traffic(100);
    drain();

    // no leader possible, every period a zero or ignored
    apply_settings('{leader_low: 16'hFFFF, leader_high: 16'h0000, bit_threshold: 16'hFFFF,
                     code_up: 8'h00, code_down: 8'hFF, code_ok: 8'h81, code_mode: 8'h00});
    test_traffic(60);
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ir_remote_time_setting_decoder_unit: match");
    end else begin
      $display("ir_remote_time_setting_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/irtd_pkg.sv
rtl/irtd_front.sv
rtl/irtd_queue.sv
rtl/irtd_back.sv
rtl/ir_remote_time_setting_decoder_unit.sv
tb/sv/tb_top.sv
